### sv/bfsa_pkg.sv
// Shared types, codes and constants for the segmented binary font to text converter.
// Used by the parser front, the job queue, the character back end and the top level.
// Depends on nothing else.
package bfsa_pkg;

    // Header and character constants.
    localparam logic [7:0] MARKER_BYTE        = 8'd128;
    localparam logic [7:0] CH_CR              = 8'd13;
    localparam logic [7:0] CH_LF              = 8'd10;
    localparam logic [7:0] HEX_PER_LINE_RESET = 8'd40;
    localparam logic [7:0] ASCII_ZERO         = 8'h30;
    localparam logic [7:0] ASCII_ALPHA_BASE   = 8'h37;  // 'A' minus ten
    localparam logic [3:0] HEX_TEN            = 4'd10;
    localparam logic [1:0] LEN_IDX_LAST       = 2'd3;

    // Configuration register indexes.
    localparam int unsigned CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_IGNORE_ERRORS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEX_PER_LINE  = 1'b1;

    // Segment type codes as held by the parser (zero means unknown).
    localparam logic [1:0] SEG_UNKNOWN = 2'd0;
    localparam logic [1:0] SEG_TEXT    = 2'd1;
    localparam logic [1:0] SEG_BINARY  = 2'd2;
    localparam logic [1:0] SEG_END     = 2'd3;

    // Job queue geometry.
    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Hex expansion steps in the back end.
    localparam logic [1:0] STEP_HIGH = 2'd0;
    localparam logic [1:0] STEP_LOW  = 2'd1;
    localparam logic [1:0] STEP_LF   = 2'd2;

    // Result kinds.
    typedef enum logic [1:0] {
        KIND_CHAR       = 2'd0,
        KIND_END        = 2'd1,
        KIND_BAD_MARKER = 2'd2,
        KIND_BAD_TYPE   = 2'd3
    } kind_t;

    // Parser phases.
    typedef enum logic [2:0] {
        PH_MARKER = 3'd0,
        PH_TYPE   = 3'd1,
        PH_LENGTH = 3'd2,
        PH_DATA   = 3'd3,
        PH_HALT   = 3'd4
    } phase_t;

    // Job operations handed from the front to the back.
    typedef enum logic [1:0] {
        OP_CHAR  = 2'd0,
        OP_HEX   = 2'd1,
        OP_EVENT = 2'd2
    } op_t;

    // One job: a text character, a byte to expand into hex, or a reported event.
    typedef struct packed {
        op_t        op;
        logic [7:0] data;
        kind_t      kind;
        logic       lf;
    } job_t;

    // Queue status seen by its neighbours.
    typedef struct packed {
        logic full;
        logic empty;
    } qstat_t;

    // Uppercase hex character for one nibble.
    function automatic logic [7:0] hex_digit(input logic [3:0] v);
        logic [7:0] ext;
        ext = {4'h0, v};
        return (v < HEX_TEN) ? (ASCII_ZERO + ext) : (ASCII_ALPHA_BASE + ext);
    endfunction

endpackage

### sv/binary_font_segment_to_ascii.sv
// Segmented binary font to text converter: an input byte is taken whenever full is low;
// header bytes give no result but for events (a bad marker, an end or a bad type), a text
// byte gives one result, a binary byte gives two hex results plus a line feed at line ends.
// Results leave at one per cycle while the user pops them, from a single output register;
// a four-entry job queue decouples the parser.
// Depends on bfsa_pkg, bfsa_front, bfsa_queue and bfsa_back.
module binary_font_segment_to_ascii
    import bfsa_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    output logic                 full,
    input  logic [7:0]           in_byte,
    output logic                 empty,
    input  logic                 pop,
    output logic [7:0]           out_char,
    output logic [1:0]           kind,
    output logic                 last_of_run,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]           cfg_data
);

    qstat_t q_stat;
    job_t   wr_job;
    job_t   rd_job;
    logic   job_push;
    logic   q_pop;
    logic   accept;

    // Input requests are taken while the queue has room.
    assign full      = q_stat.full;
    assign accept    = push && !q_stat.full;
    assign cfg_ready = 1'b1;

    bfsa_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .in_byte   (in_byte),
        .cfg_write (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .job_push  (job_push),
        .job       (wr_job)
    );

    bfsa_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (job_push),
        .wr_data (wr_job),
        .rd_en   (q_pop),
        .rd_data (rd_job),
        .stat    (q_stat)
    );

    bfsa_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_stat      (q_stat),
        .q_data      (rd_job),
        .q_pop       (q_pop),
        .pop         (pop),
        .empty       (empty),
        .out_char    (out_char),
        .kind        (kind),
        .last_of_run (last_of_run)
    );

endmodule

### sv/bfsa_front.sv
// Parser front end: holds the configuration registers and the segment header state,
// classifies each input byte and writes at most one job per byte into the job queue.
// Depends on bfsa_pkg.
module bfsa_front
    import bfsa_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 accept,
    input  logic [7:0]           in_byte,
    input  logic                 cfg_write,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]           cfg_data,
    output logic                 job_push,
    output job_t                 job
);

    phase_t      phase_reg, phase_next;
    logic [1:0]  seg_type_reg, seg_type_next;
    logic [31:0] remain_reg, remain_next;
    logic [1:0]  len_idx_reg, len_idx_next;
    logic [7:0]  line_cnt_reg, line_cnt_next;
    logic        ignore_reg;
    logic [7:0]  per_line_reg;

    logic [31:0] remain_full;
    logic [7:0]  line_inc;
    logic        line_wrap;

    // Length as it stands once the current byte is merged in.
    always_comb
    begin
        remain_full = remain_reg;
        case (len_idx_reg)
            2'd0:    remain_full[7:0]   = in_byte;
            2'd1:    remain_full[15:8]  = in_byte;
            2'd2:    remain_full[23:16] = in_byte;
            default: remain_full[31:24] = in_byte;
        endcase
    end

    // Line counter for binary data.
    assign line_inc  = line_cnt_reg + 8'd1;
    assign line_wrap = (line_inc == per_line_reg);

    // Next phase.
    always_comb
    begin
        phase_next = phase_reg;
        unique case (phase_reg)
            PH_MARKER:
            begin
                if (in_byte == MARKER_BYTE || ignore_reg)
                    phase_next = PH_TYPE;
                else
                    phase_next = PH_HALT;
            end
            PH_TYPE:
                phase_next = PH_LENGTH;
            PH_LENGTH:
            begin
                if (len_idx_reg != LEN_IDX_LAST)
                    phase_next = PH_LENGTH;
                else if (seg_type_reg == SEG_END)
                    phase_next = PH_MARKER;
                else if (seg_type_reg == SEG_UNKNOWN)
                    phase_next = ignore_reg ? PH_MARKER : PH_HALT;
                else
                    phase_next = (remain_full != 32'd0) ? PH_DATA : PH_MARKER;
            end
            PH_DATA:
                phase_next = (remain_reg == 32'd1) ? PH_MARKER : PH_DATA;
            PH_HALT:
                phase_next = PH_HALT;
            default:
                phase_next = PH_HALT;
        endcase
    end

    // Header datapath and job generation.
    always_comb
    begin
        seg_type_next = seg_type_reg;
        remain_next   = remain_reg;
        len_idx_next  = len_idx_reg;
        line_cnt_next = line_cnt_reg;
        job_push      = 1'b0;
        job.op        = OP_EVENT;
        job.data      = 8'd0;
        job.kind      = KIND_CHAR;
        job.lf        = 1'b0;
        unique case (phase_reg)
            PH_MARKER:
            begin
                if (in_byte != MARKER_BYTE)
                begin
                    job_push = accept;
                    job.kind = KIND_BAD_MARKER;
                end
            end
            PH_TYPE:
            begin
                seg_type_next = (in_byte[7:2] == 6'd0) ? in_byte[1:0] : SEG_UNKNOWN;
                remain_next   = 32'd0;
                len_idx_next  = 2'd0;
            end
            PH_LENGTH:
            begin
                remain_next = remain_full;
                if (len_idx_reg != LEN_IDX_LAST)
                    len_idx_next = len_idx_reg + 2'd1;
                else
                begin
                    len_idx_next  = 2'd0;
                    line_cnt_next = 8'd0;
                    if (seg_type_reg == SEG_END)
                    begin
                        job_push = accept;
                        job.kind = KIND_END;
                    end
                    else if (seg_type_reg == SEG_UNKNOWN)
                    begin
                        job_push = accept;
                        job.kind = KIND_BAD_TYPE;
                    end
                end
            end
            PH_DATA:
            begin
                remain_next = remain_reg - 32'd1;
                job_push    = accept;
                if (seg_type_reg == SEG_TEXT)
                begin
                    job.op   = OP_CHAR;
                    job.data = (in_byte == CH_CR) ? CH_LF : in_byte;
                end
                else
                begin
                    job.op        = OP_HEX;
                    job.data      = in_byte;
                    job.lf        = line_wrap;
                    line_cnt_next = line_wrap ? 8'd0 : line_inc;
                end
            end
            PH_HALT:
            begin
            end
            default:
            begin
            end
        endcase
    end

    // Parser state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_MARKER;
            seg_type_reg <= SEG_UNKNOWN;
            remain_reg   <= 32'd0;
            len_idx_reg  <= 2'd0;
            line_cnt_reg <= 8'd0;
        end
        else if (accept)
        begin
            phase_reg    <= phase_next;
            seg_type_reg <= seg_type_next;
            remain_reg   <= remain_next;
            len_idx_reg  <= len_idx_next;
            line_cnt_reg <= line_cnt_next;
        end
    end

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ignore_reg   <= 1'b0;
            per_line_reg <= HEX_PER_LINE_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_IGNORE_ERRORS: ignore_reg   <= cfg_data[0];
                CFG_HEX_PER_LINE:  per_line_reg <= cfg_data;
                default:           ignore_reg   <= ignore_reg;
            endcase
        end
    end

endmodule

### sv/bfsa_queue.sv
// Short job queue between the parser front and the character back end.
// Register array with read and write pointers and an occupancy count.
// Depends on bfsa_pkg.
module bfsa_queue
    import bfsa_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   wr_en,
    input  job_t   wr_data,
    input  logic   rd_en,
    output job_t   rd_data,
    output qstat_t stat
);

    job_t              entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg, count_next;

    assign stat.full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign stat.empty = (count_reg == '0);
    assign rd_data    = entry_reg[rd_ptr_reg];

    // Occupancy follows the two request strobes.
    always_comb
    begin
        count_next = count_reg;
        if (wr_en && !rd_en)
            count_next = count_reg + 1'b1;
        else if (rd_en && !wr_en)
            count_next = count_reg - 1'b1;
    end

    // Storage.
    always_ff @(posedge clk)
    begin
        if (wr_en)
            entry_reg[wr_ptr_reg] <= wr_data;
    end

    // Pointers and count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (wr_en)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (rd_en)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

    // The count never exceeds the depth.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QCNT_W'(QUEUE_DEPTH))
        else $error("job queue count out of range");

    // An empty queue has its pointers together.
    a_empty_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("job queue pointers disagree with empty count");

endmodule

### sv/bfsa_back.sv
// Character back end: takes jobs from the queue and expands each into one to three
// results, one result per cycle unless the output stage is full and not popped, into a registered output stage.
// Depends on bfsa_pkg.
module bfsa_back
    import bfsa_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  qstat_t     q_stat,
    input  job_t       q_data,
    output logic       q_pop,
    input  logic       pop,
    output logic       empty,
    output logic [7:0] out_char,
    output logic [1:0] kind,
    output logic       last_of_run
);

    job_t       cur_reg;
    logic       cur_valid_reg, cur_valid_next;
    logic [1:0] step_reg, step_next;
    logic       out_valid_reg, out_valid_next;
    logic [7:0] out_char_reg;
    kind_t      kind_reg;
    logic       last_reg;

    logic       emit;
    logic       is_last;
    logic [7:0] res_char;
    kind_t      res_kind;

    // Result selected by the current job and expansion step.
    always_comb
    begin
        res_char = 8'd0;
        res_kind = KIND_CHAR;
        is_last  = 1'b1;
        case (cur_reg.op)
            OP_CHAR:
                res_char = cur_reg.data;
            OP_HEX:
            begin
                case (step_reg)
                    STEP_HIGH:
                    begin
                        res_char = hex_digit(cur_reg.data[7:4]);
                        is_last  = 1'b0;
                    end
                    STEP_LOW:
                    begin
                        res_char = hex_digit(cur_reg.data[3:0]);
                        is_last  = !cur_reg.lf;
                    end
                    default:
                        res_char = CH_LF;
                endcase
            end
            default:
                res_kind = cur_reg.kind;
        endcase
    end

    // A result moves out when the output stage is free or is being taken.
    assign emit  = cur_valid_reg && (!out_valid_reg || pop);
    assign q_pop = !q_stat.empty && (!cur_valid_reg || (emit && is_last));

    always_comb
    begin
        cur_valid_next = cur_valid_reg;
        step_next      = step_reg;
        if (emit)
            step_next = is_last ? STEP_HIGH : (step_reg + 2'd1);
        if (q_pop)
            cur_valid_next = 1'b1;
        else if (emit && is_last)
            cur_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (emit)
            out_valid_next = 1'b1;
        else if (pop)
            out_valid_next = 1'b0;
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            step_reg      <= STEP_HIGH;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cur_valid_reg <= cur_valid_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (q_pop)
            cur_reg <= q_data;
        if (emit)
        begin
            out_char_reg <= res_char;
            kind_reg     <= res_kind;
            last_reg     <= is_last;
        end
    end

    assign empty       = !out_valid_reg;
    assign out_char    = out_char_reg;
    assign kind        = kind_reg;
    assign last_of_run = last_reg;

    // Event results carry no character and always close their run.
    a_event_shape: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && kind_reg != KIND_CHAR) |-> (out_char_reg == 8'd0 && last_reg))
        else $error("event result with character or open run");

    // Only a hex job advances past its first step.
    a_step_hex: assert property (@(posedge clk) disable iff (!rst_n)
        (cur_valid_reg && step_reg != STEP_HIGH) |-> (cur_reg.op == OP_HEX))
        else $error("expansion step on a non-hex job");

endmodule
